>>> src/shb_pkg.sv
// ----------------------------------------------------------------------------
// shb_pkg
// Shared constants, codes and control types of the string hash bucket unit.
// ----------------------------------------------------------------------------
package shb_pkg;

  localparam int HASH_WIDTH = 64;
  localparam int BYTE_W     = 8;
  localparam int BUCKET_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int MODE_W     = 2;
  localparam int CNT_W      = $clog2(HASH_WIDTH);

  localparam int PJW_SHIFT  = HASH_WIDTH / 8;
  localparam int PJW_FOLD   = (HASH_WIDTH / 8) * 6;
  localparam int MUL_SH_HI  = 7;
  localparam int MUL_SH_LO  = 1;
  localparam int SAX_SH_L   = 5;
  localparam int SAX_SH_R   = 2;

  localparam logic [HASH_WIDTH-1:0] PJW_TOP = {4'hF, {(HASH_WIDTH-4){1'b0}}};

  localparam logic [BUCKET_W-1:0] BUCKET_RESET = BUCKET_W'(53);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HASH_MODE      = 2'd0,
    REG_BUCKET_COUNT   = 2'd1,
    REG_ZERO_BYTE_ENDS = 2'd2
  } reg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PJW = 2'd0,
    MODE_MUL = 2'd1,
    MODE_SAX = 2'd2
  } hash_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic byte_en;
    logic div_start;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

>>> src/shb_if.sv
// ----------------------------------------------------------------------------
// shb_if
// Handshake channels: byte input, bucket result and register write.
// ----------------------------------------------------------------------------
interface shb_byte_if import shb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface shb_result_if import shb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BUCKET_W-1:0] bucket_index;

  modport source (output valid, output bucket_index, input ready);
  modport sink   (input valid, input bucket_index, output ready);
endinterface

interface shb_cfg_if import shb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/shb_ctrl.sv
// ----------------------------------------------------------------------------
// shb_ctrl
// Sequencer: takes bytes, runs the modulo, hands the result to the output.
// ----------------------------------------------------------------------------
module shb_ctrl import shb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.byte_en = 1'b1;
          if (in_last) begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

>>> src/shb_dp.sv
// ----------------------------------------------------------------------------
// shb_dp
// Registers, running hash update and bit-serial restoring modulo.
// ----------------------------------------------------------------------------
module shb_dp import shb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic [BYTE_W-1:0]     data_byte,
  input  logic                  last_byte,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [BUCKET_W-1:0]   bucket_index
);

  logic [MODE_W-1:0]     hash_mode;
  logic [BUCKET_W-1:0]   bucket_count;
  logic                  zero_byte_ends;

  logic [HASH_WIDTH-1:0] running_hash;
  logic                  string_stopped;
  logic [HASH_WIDTH-1:0] hash_next;
  logic                  stop_now;

  logic [HASH_WIDTH-1:0] b_ext;
  logic [HASH_WIDTH-1:0] pjw_sum;
  logic [HASH_WIDTH-1:0] pjw_top;
  logic [HASH_WIDTH-1:0] pjw_val;
  logic [HASH_WIDTH-1:0] mul_val;
  logic [HASH_WIDTH-1:0] sax_val;

  logic [HASH_WIDTH-1:0] dividend;
  logic [BUCKET_W-1:0]   divisor;
  logic [BUCKET_W-1:0]   rem;
  logic [CNT_W-1:0]      count;
  logic [BUCKET_W:0]     trial;
  logic [BUCKET_W:0]     trial_diff;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mode      <= MODE_PJW;
      bucket_count   <= BUCKET_RESET;
      zero_byte_ends <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HASH_MODE:      hash_mode      <= cfg_data[MODE_W-1:0];
        REG_BUCKET_COUNT:   bucket_count   <= cfg_data[BUCKET_W-1:0];
        REG_ZERO_BYTE_ENDS: zero_byte_ends <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // hash update
  assign b_ext   = {{(HASH_WIDTH-BYTE_W){1'b0}}, data_byte};
  assign pjw_sum = (running_hash << PJW_SHIFT) + b_ext;
  assign pjw_top = pjw_sum & PJW_TOP;
  assign pjw_val = pjw_sum ^ (pjw_top >> PJW_FOLD) ^ pjw_top;
  assign mul_val = (running_hash << MUL_SH_HI) + (running_hash << MUL_SH_LO)
                 + running_hash + b_ext;
  assign sax_val = running_hash ^ ((running_hash << SAX_SH_L)
                 + (running_hash >> SAX_SH_R) + b_ext);

  assign stop_now = (data_byte == '0) && zero_byte_ends;

  always_comb begin
    hash_next = running_hash;
    if (!string_stopped && !stop_now) begin
      case (hash_mode)
        MODE_MUL: hash_next = mul_val;
        MODE_SAX: hash_next = sax_val;
        default:  hash_next = pjw_val;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash   <= '0;
      string_stopped <= 1'b0;
    end else if (cmd.byte_en) begin
      if (last_byte) begin
        running_hash   <= '0;
        string_stopped <= 1'b0;
      end else begin
        running_hash   <= hash_next;
        string_stopped <= string_stopped | stop_now;
      end
    end
  end

  // restoring modulo, one dividend bit per cycle, MSB first
  assign trial      = {rem, dividend[HASH_WIDTH-1]};
  assign trial_diff = trial - {1'b0, divisor};
  assign status.div_last = (count == '0);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dividend <= hash_next;
      divisor  <= bucket_count;
      rem      <= '0;
      count    <= CNT_W'(HASH_WIDTH - 1);
    end else if (cmd.div_step) begin
      dividend <= dividend << 1;
      count    <= count - CNT_W'(1);
      if (trial >= {1'b0, divisor}) begin
        rem <= trial_diff[BUCKET_W-1:0];
      end else begin
        rem <= trial[BUCKET_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bucket_index <= (divisor == '0) ? '0 : rem;
    end
  end

endmodule

>>> src/string_hash_bucket_unit_top.sv
// ----------------------------------------------------------------------------
// string_hash_bucket_unit_top
// Per-string hash (PJW fold, x131, shift-add-xor) reduced modulo bucket count.
//
//   channel   dir   payload                     request
//   byte_ch   in    data_byte[7:0], last_byte   one string byte
//   result_ch out   bucket_index[31:0]          one result per string
//   cfg       in    index[1:0], data[31:0]      one register write
//
// A byte that is not last updates the running hash and leaves the unit ready.
// A last byte starts the bit-serial modulo: the shared subtract/compare step
// runs once per hash bit, then the output register is loaded, and only then
// is the next byte taken.
// The output register holds the result while result_ch stalls; a following
// string can be hashed and reduced meanwhile, and only the byte after its
// last byte waits until the output register is free.
// Synchronous reset restores the register defaults and clears the hash.
// ----------------------------------------------------------------------------
module string_hash_bucket_unit_top import shb_pkg::*; (
  input logic         clk,
  input logic         rst,
  shb_byte_if.sink    byte_ch,
  shb_result_if.source result_ch,
  shb_cfg_if.sink     cfg
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  shb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (byte_ch.valid),
    .in_last   (byte_ch.last_byte),
    .in_ready  (byte_ch.ready),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  shb_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .data_byte    (byte_ch.data_byte),
    .last_byte    (byte_ch.last_byte),
    .cfg_write    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .bucket_index (result_ch.bucket_index)
  );

endmodule

>>> src/shb_checker.sv
// ----------------------------------------------------------------------------
// shb_checker
// Port-level checks of the string hash bucket unit, bound to the top level.
// ----------------------------------------------------------------------------
module shb_checker import shb_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_last,
  input logic                out_valid,
  input logic                out_ready,
  input logic [BUCKET_W-1:0] out_index
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_index))
    else $error("result payload changed while stalled");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_last |=> !in_ready)
    else $error("byte taken while modulo in progress");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_acc))
    else $error("result appeared right after a byte request");

endmodule

bind string_hash_bucket_unit_top shb_checker u_shb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (byte_ch.valid),
  .in_ready  (byte_ch.ready),
  .in_last   (byte_ch.last_byte),
  .out_valid (result_ch.valid),
  .out_ready (result_ch.ready),
  .out_index (result_ch.bucket_index)
);
